// ----- rtl/core/websocket_frame_deframer_macros.svh -----
// Assertion macros used by the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- rtl/core/wsfd_pkg.sv -----
// Package: types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsfd_pkg;

  localparam int LEN_W    = 63;
  localparam int TDATA_W  = 72;
  localparam int TUSER_W  = 10;

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [LEN_W-1:0] payload_length;
    logic             was_masked;
    logic [3:0]       frame_opcode;
    logic [2:0]       reserved_bits;
    logic             fin_flag;
    logic             frame_last;
    logic             has_byte;
    logic [7:0]       payload_byte;
  } res_t;

endpackage

// ----- rtl/core/wsfd_in_stage.sv -----
// Input register stage of the deframer.
`timescale 1ns / 1ps
module wsfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // stream_byte
  input  logic       take,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  assign s_tready = !rst && (!in_valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

// ----- rtl/core/wsfd_parser.sv -----
// Frame header parser and payload unmasking.
`timescale 1ns / 1ps
module wsfd_parser import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output res_t       res
);

  logic [2:0]       phase, phase_next;
  logic [3:0]       hdr_cnt, hdr_cnt_next;
  logic             fin, fin_next;
  logic [2:0]       rsv, rsv_next;
  logic [3:0]       opcode, opcode_next;
  logic             masked, masked_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [31:0]      mask_key, mask_key_next;
  logic [1:0]       idx, idx_next;

  logic             len_done;
  logic             key_done;
  logic [7:0]       key_byte;
  logic             last;

  always_comb begin
    case (idx)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    fin_next       = fin;
    rsv_next       = rsv;
    opcode_next    = opcode;
    masked_next    = masked;
    len_next       = len;
    remaining_next = remaining;
    mask_key_next  = mask_key;
    idx_next       = idx;
    len_done       = 1'b0;
    key_done       = 1'b0;
    last           = 1'b0;
    res_valid      = 1'b0;
    res.payload_byte = 8'd0;
    res.has_byte     = 1'b0;
    res.frame_last   = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        masked_next   = in_byte[7];
        mask_key_next = '0;
        len_next      = '0;
        if (in_byte[6:0] == LEN_CODE16) begin
          hdr_cnt_next = EXT16_BYTES;
          phase_next   = PH_EXTLEN;
        end else if (in_byte[6:0] == LEN_CODE64) begin
          hdr_cnt_next = EXT64_BYTES;
          phase_next   = PH_EXTLEN;
        end else begin
          len_next = LEN_W'(in_byte[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXTLEN: begin
        len_next = {len[LEN_W-9:0], in_byte};
        if (hdr_cnt != 4'd0) begin
          hdr_cnt_next = hdr_cnt - 4'd1;
        end
        len_done = (hdr_cnt_next == 4'd0);
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        if (hdr_cnt != 4'd0) begin
          hdr_cnt_next = hdr_cnt - 4'd1;
        end
        key_done = (hdr_cnt_next == 4'd0);
      end
      PH_DATA: begin
        last             = (remaining == LEN_W'(1));
        remaining_next   = remaining - LEN_W'(1);
        idx_next         = idx + 2'd1;
        res_valid        = 1'b1;
        res.payload_byte = in_byte ^ key_byte;
        res.has_byte     = 1'b1;
        res.frame_last   = last;
        if (last) begin
          phase_next = PH_HDR0;
          idx_next   = 2'd0;
        end
      end
      default: begin
        fin_next     = in_byte[7];
        rsv_next     = in_byte[6:4];
        opcode_next  = in_byte[3:0];
        hdr_cnt_next = 4'd0;
        phase_next   = PH_HDR1;
      end
    endcase

    if (len_done && masked_next) begin
      hdr_cnt_next = KEY_BYTES;
      phase_next   = PH_KEY;
    end else if (len_done || key_done) begin
      idx_next       = 2'd0;
      remaining_next = len_next;
      if (len_next == '0) begin
        phase_next     = PH_HDR0;
        res_valid      = 1'b1;
        res.frame_last = 1'b1;
      end else begin
        phase_next = PH_DATA;
      end
    end

    res.fin_flag       = fin_next;
    res.reserved_bits  = rsv_next;
    res.frame_opcode   = opcode_next;
    res.was_masked     = masked_next;
    res.payload_length = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      hdr_cnt   <= 4'd0;
      fin       <= 1'b0;
      rsv       <= 3'd0;
      opcode    <= 4'd0;
      masked    <= 1'b0;
      len       <= '0;
      remaining <= '0;
      mask_key  <= 32'd0;
      idx       <= 2'd0;
    end else if (take) begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      fin       <= fin_next;
      rsv       <= rsv_next;
      opcode    <= opcode_next;
      masked    <= masked_next;
      len       <= len_next;
      remaining <= remaining_next;
      mask_key  <= mask_key_next;
      idx       <= idx_next;
    end
  end

endmodule

// ----- rtl/core/wsfd_out_buf.sv -----
// Two-entry result buffer in front of the master port.
`timescale 1ns / 1ps
module wsfd_out_buf import wsfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  res_t wr_res,
  output logic space,
  output logic m_tvalid,
  input  logic m_tready,
  output res_t rd_res
);

  res_t       ent0;
  res_t       ent1;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       rd_en;

  assign space    = (cnt != 2'd2);
  assign m_tvalid = (cnt != 2'd0);
  assign rd_en    = m_tvalid && m_tready;
  assign rd_res   = rd_ptr ? ent1 : ent0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_ptr) begin
      ent0 <= wr_res;
    end
    if (wr_en && wr_ptr) begin
      ent1 <= wr_res;
    end
  end

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer.
//
//  port group | role   | tdata                          | tuser / tlast
//  s_*        | input  | stream_byte                    | -
//  m_*        | output | payload_byte, payload_length   | flags, opcode / frame_last
//
// One byte per cycle sustained while the result buffer has space; a byte is registered in
// the input stage, then its result is written to the result buffer, from which it transfers on m_*.
// Header bytes produce no result, but the last one of an empty frame does; every payload byte does.
// Reset is synchronous; s_tready is low while rst is high.
// A two-entry result buffer absorbs m_tready stalls; s_tready comes from rst and registers.
`timescale 1ns / 1ps
module websocket_frame_deframer import wsfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] stream_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [70:8] payload_length, [71] 0
  output logic               m_tlast,   // frame_last
  output logic [TUSER_W-1:0] m_tuser    // [0] has_byte, [1] fin_flag, [4:2] reserved_bits,
                                        // [8:5] frame_opcode, [9] was_masked
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       space;
  logic       take;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign take = in_valid && space;

  wsfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take && res_valid),
    .wr_res   (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .rd_res   (out_res)
  );

  assign m_tdata = {1'b0, out_res.payload_length, out_res.payload_byte};
  assign m_tlast = out_res.frame_last;
  assign m_tuser = {out_res.was_masked, out_res.frame_opcode, out_res.reserved_bits,
                    out_res.fin_flag, out_res.has_byte};

endmodule

// ----- rtl/core/wsfd_checker.sv -----
// Port-level checks of the deframer, bound to the top level.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"
module wsfd_checker import wsfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast,
  input logic [TUSER_W-1:0] m_tuser
);

  logic [TDATA_W+TUSER_W:0] m_word;
  logic                     m_stall;
  logic                     m_empty;
  logic                     m_data;
  logic [7:0]               m_byte;
  logic [LEN_W-1:0]         m_len;

  assign m_word  = {m_tlast, m_tuser, m_tdata};
  assign m_stall = m_tvalid && !m_tready;
  assign m_empty = m_tvalid && !m_tuser[0];
  assign m_data  = m_tvalid && m_tuser[0];
  assign m_byte  = m_tdata[7:0];
  assign m_len   = m_tdata[70:8];

  `WSFD_ASSERT_NEXT(a_hold_stall, clk, rst, m_stall, m_tvalid && $stable(m_word))
  `WSFD_ASSERT_NOW(a_empty_frame, clk, rst, m_empty, m_tlast && m_byte == 8'd0 && m_len == '0)
  `WSFD_ASSERT_NOW(a_data_len, clk, rst, m_data, m_len != '0)
  `WSFD_ASSERT_NOW(a_after_reset, clk, rst, $past(rst), !m_tvalid)

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
